// ----- src/pcen_pkg.sv -----
// Shared types and constants for the polygon centroid core.
`default_nettype none
package pcen_pkg;

  // Field widths fixed by the stream formats
  localparam int FIELD_W     = 16;
  localparam int OUT_W       = 24;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 56;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_VERTICES = 1024;
  localparam int DEF_COORD_BITS   = 16;
  localparam int DEF_FRAC_BITS    = 8;

  // Entries in the command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FEW  = 2'd1,
    ST_ZERO = 2'd2,
    ST_MANY = 2'd3
  } status_t;

  typedef logic signed [FIELD_W-1:0] coord_t;

  // One unit of work for the back end: an optional edge, optionally closing
  typedef struct packed {
    logic    has_edge;
    logic    fin;
    status_t st;
    coord_t  xa;
    coord_t  ya;
    coord_t  xb;
    coord_t  yb;
  } cmd_t;

endpackage
`default_nettype wire

// ----- src/pcen_front.sv -----
// Front end: accepts vertices, tracks first/previous vertex and count, issues edge commands.
`default_nettype none
module pcen_front #(
  parameter int MAX_VERTICES = 1024,
  parameter int COORD_BITS   = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [pcen_pkg::IN_TDATA_W-1:0] in_tdata,  // vertex_x [15:0], vertex_y [31:16]
  input  wire logic                           in_tlast,  // last_vertex
  output logic                                push_valid,
  input  wire logic                           push_ready,
  output pcen_pkg::cmd_t                      push_cmd
);
  import pcen_pkg::*;

  localparam int CNT_W = $clog2(MAX_VERTICES + 2);
  localparam logic [CNT_W-1:0] MAX_C   = CNT_W'(MAX_VERTICES);
  localparam logic [CNT_W-1:0] THREE_C = CNT_W'(3);
  localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

  logic [CNT_W-1:0] cnt_r;
  logic             pend_r;
  cmd_t             pend_cmd_r;
  coord_t           first_x_r, first_y_r, prev_x_r, prev_y_r;

  coord_t           cur_x, cur_y, fx, fy;
  logic [CNT_W-1:0] cnt_inc;
  logic             mid_edge, accept;
  cmd_t             edge_cmd, close_cmd;

  // Coordinates come from the low COORD_BITS of each field, sign-extended
  assign cur_x = coord_t'(signed'(in_tdata[COORD_BITS-1:0]));
  assign cur_y = coord_t'(signed'(in_tdata[FIELD_W+COORD_BITS-1:FIELD_W]));

  // Classify the incoming vertex
  always_comb begin
    cnt_inc  = (cnt_r <= MAX_C) ? cnt_r + ONE_C : cnt_r;
    mid_edge = (cnt_r != '0) && (cnt_r < MAX_C);
    fx       = (cnt_r == '0) ? cur_x : first_x_r;
    fy       = (cnt_r == '0) ? cur_y : first_y_r;

    edge_cmd.has_edge = 1'b1;
    edge_cmd.fin      = 1'b0;
    edge_cmd.st       = ST_OK;
    edge_cmd.xa       = prev_x_r;
    edge_cmd.ya       = prev_y_r;
    edge_cmd.xb       = cur_x;
    edge_cmd.yb       = cur_y;

    close_cmd.has_edge = (cnt_inc <= MAX_C);
    close_cmd.fin      = 1'b1;
    if (cnt_inc < THREE_C) begin
      close_cmd.st = ST_FEW;
    end else if (cnt_inc > MAX_C) begin
      close_cmd.st = ST_MANY;
    end else begin
      close_cmd.st = ST_OK;
    end
    close_cmd.xa = cur_x;
    close_cmd.ya = cur_y;
    close_cmd.xb = fx;
    close_cmd.yb = fy;
  end

  // Handshake: a pending closing command blocks new vertices
  assign in_tready  = !pend_r && push_ready;
  assign accept     = in_tvalid && in_tready;
  assign push_valid = pend_r || (accept && (mid_edge || in_tlast));
  assign push_cmd   = pend_r ? pend_cmd_r : (mid_edge ? edge_cmd : close_cmd);

  // Polygon state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      pend_r     <= 1'b0;
      pend_cmd_r <= '0;
      first_x_r  <= '0;
      first_y_r  <= '0;
      prev_x_r   <= '0;
      prev_y_r   <= '0;
    end else begin
      if (pend_r && push_ready) begin
        pend_r <= 1'b0;
      end
      if (accept) begin
        if (cnt_r < MAX_C) begin
          if (cnt_r == '0) begin
            first_x_r <= cur_x;
            first_y_r <= cur_y;
          end
          prev_x_r <= cur_x;
          prev_y_r <= cur_y;
        end
        cnt_r <= in_tlast ? '0 : cnt_inc;
        if (in_tlast && mid_edge) begin
          pend_r     <= 1'b1;
          pend_cmd_r <= close_cmd;
        end
      end
    end
  end

  // Count never passes the saturation point
  a_cnt_sat: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MAX_C + ONE_C)
    else $error("vertex count beyond saturation");

endmodule
`default_nettype wire

// ----- src/pcen_queue.sv -----
// Short command queue between the front and back ends.
`default_nettype none
module pcen_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push_valid,
  output logic                push_ready,
  input  wire pcen_pkg::cmd_t push_cmd,
  output logic                pop_valid,
  input  wire logic           pop_ready,
  output pcen_pkg::cmd_t      pop_cmd
);
  import pcen_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_C = CNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_P = PTR_W'(QUEUE_DEPTH - 1);

  cmd_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign push_ready = (cnt_r != FULL_C);
  assign pop_valid  = (cnt_r != '0);
  assign pop_cmd    = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_P) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_P) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + CNT_W'(1);
        2'b01:   cnt_r <= cnt_r - CNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_C)
    else $error("queue fill count overflow");

endmodule
`default_nettype wire

// ----- src/pcen_div.sv -----
// Restoring divider: moment / (3 * area) in fixed point, truncated and saturated.
`default_nettype none
module pcen_div #(
  parameter int NUM_W     = 61,
  parameter int AREA_W    = 44,
  parameter int FRAC_BITS = 8,
  parameter int OUT_BITS  = 24
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic signed [NUM_W-1:0]  num,
  input  wire logic signed [AREA_W-1:0] area,
  output logic                          done,
  output logic [OUT_BITS-1:0]           quo
);
  localparam int D_W   = AREA_W + 2;
  localparam int N_W   = NUM_W + FRAC_BITS;
  localparam int CNT_W = $clog2(N_W + 1);
  localparam logic [N_W-1:0]   LIM_P  = N_W'((64'd1 << (OUT_BITS - 1)) - 64'd1);
  localparam logic [N_W-1:0]   LIM_N  = N_W'(64'd1 << (OUT_BITS - 1));
  localparam logic [CNT_W-1:0] LAST_C = CNT_W'(N_W - 1);

  logic                busy_r, done_r, neg_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [N_W-1:0]      n_r, q_r;
  logic [D_W-1:0]      den_r, rem_r;

  logic [NUM_W-1:0]    mag;
  logic [AREA_W-1:0]   amag;
  logic [D_W:0]        rem_sh;
  logic                ge;
  logic [N_W-1:0]      lim, val_w;
  logic [OUT_BITS-1:0] val;

  // Operand magnitudes and one quotient bit per cycle
  always_comb begin
    mag    = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    amag   = area[AREA_W-1] ? AREA_W'(-area) : AREA_W'(area);
    rem_sh = {rem_r, n_r[N_W-1]};
    ge     = (rem_sh >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      neg_r  <= 1'b0;
      n_r    <= '0;
      q_r    <= '0;
      den_r  <= '0;
      rem_r  <= '0;
    end else begin
      // one-cycle pulse after the last quotient bit
      done_r <= busy_r && !start && (cnt_r == LAST_C);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        neg_r  <= num[NUM_W-1] ^ area[AREA_W-1];
        n_r    <= N_W'(mag) << FRAC_BITS;
        den_r  <= (D_W'(amag) << 1) + D_W'(amag);
        rem_r  <= '0;
        q_r    <= '0;
      end else if (busy_r) begin
        rem_r <= ge ? D_W'(rem_sh - {1'b0, den_r}) : rem_sh[D_W-1:0];
        q_r   <= {q_r[N_W-2:0], ge};
        n_r   <= n_r << 1;
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == LAST_C) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Saturate the magnitude, then apply the sign
  always_comb begin
    lim   = neg_r ? LIM_N : LIM_P;
    val_w = (q_r > lim) ? lim : q_r;
    val   = val_w[OUT_BITS-1:0];
    quo   = neg_r ? OUT_BITS'(-val) : val;
  end

  assign done = done_r;

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider restarted while busy");

endmodule
`default_nettype wire

// ----- src/pcen_back.sv -----
// Back end: shoelace accumulation on a shared multiplier, centroid division, result register.
`default_nettype none
module pcen_back #(
  parameter int MAX_VERTICES = 1024,
  parameter int COORD_BITS   = 16,
  parameter int FRAC_BITS    = 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            pop_valid,
  output logic                                 pop_ready,
  input  wire pcen_pkg::cmd_t                  pop_cmd,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [pcen_pkg::OUT_TDATA_W-1:0]     out_tdata  // centroid_x [23:0], centroid_y [47:24], status [49:48]
);
  import pcen_pkg::*;

  localparam int CW      = COORD_BITS;
  localparam int A_W     = CW + 1;
  localparam int C_W     = 2 * CW + 1;
  localparam int P_W     = A_W + C_W;
  localparam int LOG_MAX = $clog2(MAX_VERTICES);
  localparam int AREA_W  = 2 * CW + 2 + LOG_MAX;
  localparam int MOM_W   = 3 * CW + 3 + LOG_MAX;
  localparam int PAD_W   = OUT_TDATA_W - 2 * OUT_W - 2;

  typedef enum logic [3:0] {
    S_IDLE, S_E0, S_E1, S_E2, S_E3, S_E4, S_FIN, S_DIVX, S_DIVY, S_DONE
  } state_t;

  state_t                    state_r;
  cmd_t                      cur_r;
  logic signed [P_W-1:0]     prod_r;
  logic signed [C_W-1:0]     c_r;
  logic signed [AREA_W-1:0]  area_r;
  logic signed [MOM_W-1:0]   mx_r, my_r;
  logic [OUT_W-1:0]          cx_r, cy_r, ox_r, oy_r;
  status_t                   st_r, ost_r;
  logic                      out_valid_r;

  logic signed [CW-1:0]      xa_c, ya_c, xb_c, yb_c;
  logic signed [A_W-1:0]     ma, sum_x, sum_y;
  logic signed [C_W-1:0]     mb;
  logic signed [P_W-1:0]     mult;
  logic                      div_start, div_done, go_div;
  logic signed [MOM_W-1:0]   div_num;
  logic [OUT_W-1:0]          div_quo;

  assign xa_c  = cur_r.xa[CW-1:0];
  assign ya_c  = cur_r.ya[CW-1:0];
  assign xb_c  = cur_r.xb[CW-1:0];
  assign yb_c  = cur_r.yb[CW-1:0];
  assign sum_x = A_W'(xa_c) + A_W'(xb_c);
  assign sum_y = A_W'(ya_c) + A_W'(yb_c);

  // Shared multiplier operand selection
  always_comb begin
    unique case (state_r)
      S_E0: begin ma = A_W'(xa_c); mb = C_W'(yb_c); end
      S_E1: begin ma = A_W'(xb_c); mb = C_W'(ya_c); end
      S_E2: begin ma = sum_x;      mb = c_r;        end
      S_E3: begin ma = sum_y;      mb = c_r;        end
      default: begin ma = '0;      mb = '0;         end
    endcase
  end
  assign mult = ma * mb;

  assign pop_ready = (state_r == S_IDLE);
  assign go_div    = (cur_r.st == ST_OK) && (area_r != '0);
  assign div_start = ((state_r == S_FIN) && go_div) || ((state_r == S_DIVX) && div_done);
  assign div_num   = (state_r == S_FIN) ? mx_r : my_r;

  pcen_div #(
    .NUM_W     (MOM_W),
    .AREA_W    (AREA_W),
    .FRAC_BITS (FRAC_BITS),
    .OUT_BITS  (OUT_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .area  (area_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Sequencer, accumulators and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_r       <= '0;
      prod_r      <= '0;
      c_r         <= '0;
      area_r      <= '0;
      mx_r        <= '0;
      my_r        <= '0;
      cx_r        <= '0;
      cy_r        <= '0;
      st_r        <= ST_OK;
      ox_r        <= '0;
      oy_r        <= '0;
      ost_r       <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      // drain the output register unless S_DONE reloads it
      if (out_valid_r && out_tready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (pop_valid) begin
            cur_r   <= pop_cmd;
            state_r <= pop_cmd.has_edge ? S_E0 : S_FIN;
          end
        end
        S_E0: begin
          prod_r  <= mult;
          state_r <= S_E1;
        end
        S_E1: begin
          c_r     <= prod_r[C_W-1:0] - mult[C_W-1:0];
          state_r <= S_E2;
        end
        S_E2: begin
          prod_r  <= mult;
          area_r  <= area_r + AREA_W'(c_r);
          state_r <= S_E3;
        end
        S_E3: begin
          mx_r    <= mx_r + MOM_W'(prod_r);
          prod_r  <= mult;
          state_r <= S_E4;
        end
        S_E4: begin
          my_r    <= my_r + MOM_W'(prod_r);
          state_r <= cur_r.fin ? S_FIN : S_IDLE;
        end
        S_FIN: begin
          cx_r <= '0;
          cy_r <= '0;
          if (cur_r.st != ST_OK) begin
            st_r    <= cur_r.st;
            state_r <= S_DONE;
          end else if (area_r == '0) begin
            st_r    <= ST_ZERO;
            state_r <= S_DONE;
          end else begin
            st_r    <= ST_OK;
            state_r <= S_DIVX;
          end
        end
        S_DIVX: begin
          if (div_done) begin
            cx_r    <= div_quo;
            state_r <= S_DIVY;
          end
        end
        S_DIVY: begin
          if (div_done) begin
            cy_r    <= div_quo;
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            ox_r        <= cx_r;
            oy_r        <= cy_r;
            ost_r       <= st_r;
            out_valid_r <= 1'b1;
            area_r      <= '0;
            mx_r        <= '0;
            my_r        <= '0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {PAD_W'(0), ost_r, oy_r, ox_r};

  // A failed polygon never carries a centroid
  a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (ost_r != ST_OK)) |-> ((ox_r == '0) && (oy_r == '0)))
    else $error("nonzero centroid with failing status");

  // Division only runs on a nonzero area
  a_div_area: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DIVX) || (state_r == S_DIVY)) |-> (area_r != '0))
    else $error("division started on zero area");

endmodule
`default_nettype wire

// ----- src/polygon_centroid_core.sv -----
// Polygon centroid core: streaming shoelace centroid, top level.
//
// Input channel (in_*): one vertex per transfer, x in in_tdata[15:0], y in
// in_tdata[31:16], in_tlast marks the closing vertex of a polygon.
// Output channel (out_*): one transfer per polygon, issued after its last
// vertex: centroid_x and centroid_y in signed Q16.8 (truncated toward zero,
// saturated) and a status (0 ok, 1 fewer than three vertices, 2 zero area,
// 3 more than MAX_VERTICES vertices); centroid is zero unless status is ok.
// Throughput: the front takes one vertex a cycle while the two-entry command
// queue has room and no closing command is pending; the back takes each edge
// command in S_IDLE and steps through S_E0 to S_E4, using its single shared
// multiplier in S_E0 to S_E3, and takes no new command until it is idle again.
// The last vertex carries at most its own and the closing edge; if status is
// ok, restoring divisions for centroid_x and centroid_y precede the result.
// Reset (rst_n low, synchronous) clears all polygon state and both channels.
// A stalled receiver holds the result in the output register; the back keeps
// working on edges of the next polygon and waits only at its final result.
`default_nettype none
module polygon_centroid_core #(
  parameter int MAX_VERTICES = pcen_pkg::DEF_MAX_VERTICES,
  parameter int COORD_BITS   = pcen_pkg::DEF_COORD_BITS,
  parameter int FRAC_BITS    = pcen_pkg::DEF_FRAC_BITS
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [pcen_pkg::IN_TDATA_W-1:0]  in_tdata,   // vertex_x [15:0], vertex_y [31:16]
  input  wire logic                             in_tlast,   // last_vertex
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [pcen_pkg::OUT_TDATA_W-1:0]      out_tdata   // centroid_x [23:0], centroid_y [47:24], status [49:48]
);
  import pcen_pkg::*;

  logic push_valid, push_ready, pop_valid, pop_ready;
  cmd_t push_cmd, pop_cmd;

  pcen_front #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  pcen_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  pcen_back #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS),
    .FRAC_BITS    (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire

// ----- tb/tb_polygon_centroid_core.sv -----
// Self-checking testbench for the streaming polygon centroid core.
module tb_polygon_centroid_core;
  timeunit 1ns;
  timeprecision 1ps;

  import pcen_pkg::*;

  localparam int MAX_VERTICES    = DEF_MAX_VERTICES;
  localparam int FRAC_BITS       = DEF_FRAC_BITS;
  localparam int RANDOM_VERTICES = 650;
  localparam int LONG_HOLD       = 800;
  localparam int IDLE_LIMIT      = 4000;
  localparam int TAIL_CYCLES     = 300;

  // One expected result: both centroid coordinates and the status
  typedef struct packed {
    logic [OUT_W-1:0] cx;
    logic [OUT_W-1:0] cy;
    status_t          st;
  } centroid_t;

  // Shoelace predictor plus the queue of centroids still owed by the core
  class centroid_scoreboard;
    longint    first_x, first_y, prev_x, prev_y;
    longint    area2_sum, mom_x_sum, mom_y_sum;
    int        vert_cnt;
    centroid_t expected_q[$];
    int        errors;

    function new();
      clear_polygon();
      errors = 0;
    endfunction

    function void clear_polygon();
      first_x   = 0;
      first_y   = 0;
      prev_x    = 0;
      prev_y    = 0;
      area2_sum = 0;
      mom_x_sum = 0;
      mom_y_sum = 0;
      vert_cnt  = 0;
    endfunction

    // Cross product of one edge into the area and both moment sums
    function void add_edge(longint xa, longint ya, longint xb, longint yb);
      longint c;
      c = xa * yb - xb * ya;
      area2_sum += c;
      mom_x_sum += (xa + xb) * c;
      mom_y_sum += (ya + yb) * c;
    endfunction

    // moment / (3 * area2) in Q16.8, truncated toward zero, saturated
    function logic [OUT_W-1:0] centroid_q(longint moment, longint area2);
      bit          neg;
      longint      mag_s, den_s;
      logic [63:0] mag, den, lim, quo, rem, val;
      neg   = (moment < 0) != (area2 < 0);
      mag_s = (moment < 0) ? -moment : moment;
      den_s = (area2 < 0) ? -area2 : area2;
      mag   = mag_s;
      den   = 64'(3 * den_s);
      lim   = neg ? (64'd1 << (OUT_W - 1)) : (64'd1 << (OUT_W - 1)) - 64'd1;
      quo   = mag / den;
      rem   = mag % den;
      if (quo > (lim >> FRAC_BITS)) begin
        val = lim;
      end else begin
        val = (quo << FRAC_BITS) + ((rem << FRAC_BITS) / den);
        if (val > lim) val = lim;
      end
      if (neg) val = -val;
      return val[OUT_W-1:0];
    endfunction

    // Accepted vertex: update polygon state, queue a result on the last one
    function void note_vertex(coord_t vx, coord_t vy, logic is_last);
      longint    x, y;
      centroid_t res;
      x = vx;
      y = vy;
      // past the vertex bound only the count moves
      if (vert_cnt < MAX_VERTICES) begin
        if (vert_cnt == 0) begin
          first_x = x;
          first_y = y;
        end else begin
          add_edge(prev_x, prev_y, x, y);
        end
        prev_x = x;
        prev_y = y;
      end
      if (vert_cnt <= MAX_VERTICES) vert_cnt++;
      if (!is_last) return;

      // closing edge back to the first vertex
      if (vert_cnt <= MAX_VERTICES) add_edge(x, y, first_x, first_y);
      res.cx = '0;
      res.cy = '0;
      if (vert_cnt < 3) begin
        res.st = ST_FEW;
      end else if (vert_cnt > MAX_VERTICES) begin
        res.st = ST_MANY;
      end else if (area2_sum == 0) begin
        res.st = ST_ZERO;
      end else begin
        res.st = ST_OK;
        res.cx = centroid_q(mom_x_sum, area2_sum);
        res.cy = centroid_q(mom_y_sum, area2_sum);
      end
      expected_q.insert(expected_q.size(), res);
      clear_polygon();
    endfunction

    // Accepted result: compare field by field with the oldest expectation
    function void check_result(logic [OUT_TDATA_W-1:0] word);
      centroid_t        want;
      logic [OUT_W-1:0] got_x, got_y;
      logic [1:0]       got_st;
      logic [5:0]       pad;
      got_x  = word[23:0];
      got_y  = word[47:24];
      got_st = word[49:48];
      pad    = word[55:50];
      if (expected_q.size() == 0) begin
        $display("%0t: result with none expected: expected none, actual x %h y %h status %0d",
                 $time, got_x, got_y, got_st);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got_x !== want.cx) begin
        $display("%0t: centroid_x expected %h, actual %h", $time, want.cx, got_x);
        errors++;
      end
      if (got_y !== want.cy) begin
        $display("%0t: centroid_y expected %h, actual %h", $time, want.cy, got_y);
        errors++;
      end
      if (got_st !== want.st) begin
        $display("%0t: status expected %0d, actual %0d", $time, want.st, got_st);
        errors++;
      end
      if (pad !== '0) begin
        $display("%0t: tdata padding expected 00, actual %h", $time, pad);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // vertex_x [15:0], vertex_y [31:16]
  logic                   in_tlast;   // last_vertex
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // centroid_x [23:0], centroid_y [47:24], status [49:48]

  centroid_scoreboard sb;
  int results_done = 0;
  int idle_cycles  = 0;
  int calm_in      = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  polygon_centroid_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Idle length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic coord_t extreme_coord();
    case ($urandom_range(0, 6))
      0:       return -32768;
      1:       return -32767;
      2:       return -1;
      3:       return 0;
      4:       return 1;
      5:       return 32766;
      default: return 32767;
    endcase
  endfunction

  // One vertex transfer, after an optional idle gap
  task automatic send_vertex(input coord_t vx, input coord_t vy, input logic is_last);
    int gap;
    gap = (calm_in > 0) ? 0 : idle_len();
    if (calm_in > 0) calm_in--;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {vy, vx};
    in_tlast  <= is_last;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_polygon(input coord_t xs[$], input coord_t ys[$]);
    foreach (xs[i]) send_vertex(xs[i], ys[i], i == xs.size() - 1);
  endtask

  task automatic send_large_polygon(input int n);
    for (int i = 0; i < n; i++) send_vertex(coord_t'($urandom), coord_t'($urandom), i == n - 1);
  endtask

  // Stop offering and wait until every owed result has come out
  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Transfer monitors and the no-progress watchdog
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      sb.note_vertex(coord_t'(in_tdata[15:0]), coord_t'(in_tdata[31:16]), in_tlast);
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(out_tdata);
      results_done++;
    end
    if (rst_n && !((in_tvalid && in_tready) || (out_tvalid && out_tready))) begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
        $display("** polygon_centroid_core: FAILED **");
        $finish;
      end
    end else begin
      idle_cycles = 0;
    end
  end

  // Result receiver: random stalls, calm stretches, one long hold-off
  initial begin : result_sink
    int gap_left, calm_left, hold_left;
    bit held;
    gap_left   = 0;
    calm_left  = 0;
    hold_left  = 0;
    held       = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (!held && results_done >= 12) begin
        held      = 1'b1;
        hold_left = LONG_HOLD - 1;
        out_tready <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (calm_left > 0) calm_left--;
        else if ($urandom_range(0, 99) == 0) calm_left = $urandom_range(200, 600);
        else if ($urandom_range(0, 5) == 0) gap_left = idle_len();
      end
    end
  end

  initial begin : stimulus
    int     n, kind, shapes, random_vertices, k, x0, y0, sx, sy, len_x, len_y, d;
    coord_t xs[$], ys[$];
    sb        = new();
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tlast  = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // single vertex, then two vertices: too few
    send_vertex(-32768, 32767, 1'b1);
    send_vertex(32767, -32768, 1'b0);
    send_vertex(0, 0, 1'b1);
    // collinear triangle: zero area
    send_vertex(0, 0, 1'b0);
    send_vertex(1, 1, 1'b0);
    send_vertex(2, 2, 1'b1);
    // full-range triangle, counterclockwise
    send_vertex(-32768, -32768, 1'b0);
    send_vertex(32767, -32768, 1'b0);
    send_vertex(32767, 32767, 1'b1);
    // full-range square, clockwise: negative area
    send_vertex(-32768, -32768, 1'b0);
    send_vertex(-32768, 32767, 1'b0);
    send_vertex(32767, 32767, 1'b0);
    send_vertex(32767, -32768, 1'b1);
    // bowties with nearly cancelling lobes: centroid_x saturates low, then high
    send_vertex(0, 0, 1'b0);
    send_vertex(30000, 30000, 1'b0);
    send_vertex(30000, 1, 1'b0);
    send_vertex(0, 30000, 1'b1);
    send_vertex(0, 0, 1'b0);
    send_vertex(30000, 30000, 1'b0);
    send_vertex(30000, -1, 1'b0);
    send_vertex(0, 30000, 1'b1);
    wait_results_drained();

    // random polygons, with a few at and beyond the vertex bound
    shapes          = 0;
    random_vertices = 0;
    while (random_vertices < RANDOM_VERTICES) begin
      if (shapes == 8) begin
        send_large_polygon(MAX_VERTICES);
      end else if (shapes == 20) begin
        wait_results_drained();
      end else if (shapes == 35) begin
        send_large_polygon(MAX_VERTICES + 1);
      end else if (shapes == 60) begin
        send_large_polygon(MAX_VERTICES + 9);
      end else begin
        xs.delete();
        ys.delete();
        if ($urandom_range(0, 9) == 0) calm_in = $urandom_range(10, 40);
        kind = $urandom_range(0, 99);
        if (kind < 55) begin
          // general polygon over the whole coordinate range
          n = $urandom_range(3, 12);
          repeat (n) begin
            xs.insert(xs.size(), coord_t'($urandom));
            ys.insert(ys.size(), coord_t'($urandom));
          end
        end else if (kind < 67) begin
          // tiny coordinates: small areas and fractional centroids
          n = $urandom_range(3, 8);
          repeat (n) begin
            xs.insert(xs.size(), coord_t'($urandom_range(0, 16) - 8));
            ys.insert(ys.size(), coord_t'($urandom_range(0, 16) - 8));
          end
        end else if (kind < 75) begin
          // one or two vertices only
          n = $urandom_range(1, 2);
          repeat (n) begin
            xs.insert(xs.size(), coord_t'($urandom));
            ys.insert(ys.size(), coord_t'($urandom));
          end
        end else if (kind < 83) begin
          // points on one line: zero area
          n  = $urandom_range(3, 6);
          x0 = int'($urandom_range(0, 2000)) - 1000;
          y0 = int'($urandom_range(0, 2000)) - 1000;
          sx = int'($urandom_range(0, 200)) - 100;
          sy = int'($urandom_range(0, 200)) - 100;
          repeat (n) begin
            k = $urandom_range(0, 9);
            xs.insert(xs.size(), coord_t'(x0 + k * sx));
            ys.insert(ys.size(), coord_t'(y0 + k * sy));
          end
        end else if (kind < 92) begin
          // bowtie whose lobes almost cancel: large or saturated centroid
          len_x = $urandom_range(1000, 30000);
          len_y = $urandom_range(1000, 30000);
          d     = int'($urandom_range(0, 6)) - 3;
          x0    = int'($urandom_range(0, 4000)) - 2000;
          y0    = int'($urandom_range(0, 4000)) - 2000;
          xs = '{coord_t'(x0), coord_t'(x0 + len_x), coord_t'(x0 + len_x), coord_t'(x0)};
          ys = '{coord_t'(y0), coord_t'(y0 + len_y), coord_t'(y0 + d), coord_t'(y0 + len_y)};
        end else begin
          // coordinates at and near the field limits
          n = $urandom_range(3, 6);
          repeat (n) begin
            xs.insert(xs.size(), extreme_coord());
            ys.insert(ys.size(), extreme_coord());
          end
        end
        send_polygon(xs, ys);
        random_vertices += xs.size();
      end
      shapes++;
    end

    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending() != 0) begin
      $display("%0t: %0d results never arrived", $time, sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("** polygon_centroid_core: PASSED **");
    end else begin
      $display("** polygon_centroid_core: FAILED **");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/pcen_pkg.sv
src/pcen_front.sv
src/pcen_queue.sv
src/pcen_div.sv
src/pcen_back.sv
src/polygon_centroid_core.sv
tb/tb_polygon_centroid_core.sv
